### hw/rtl/mfwf_pkg.sv
// shared types, constants and helper functions of the multichannel fir window filter
package mfwf_pkg;

  localparam int TAP_COUNT_DEF    = 129;
  localparam int MAX_CHANNELS_DEF = 64;
  localparam int MAX_WINDOW_DEF   = 256;

  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 18;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int ACC_W       = PROD_W + 8;
  localparam int ROUND_SHIFT = 17;
  localparam int COEF_MID    = 64;
  localparam int COEF_LAST   = 128;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_WIN_STEPS     = 2'd1;
  localparam logic [1:0] REG_HOP_LENGTH    = 2'd2;

  localparam logic [6:0] CHANNEL_COUNT_RST = 7'd1;
  localparam logic [8:0] WIN_STEPS_RST     = 9'd160;
  localparam logic [9:0] HOP_LENGTH_RST    = 10'd80;

  typedef struct packed {
    logic [9:0] hop_length;
    logic [8:0] win_steps;
    logic [6:0] channel_count;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               sample_invalid;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] filtered;
    logic [5:0]         out_channel;
    logic [7:0]         out_step;
    logic               window_end;
  } out_word_t;

  // first half of the symmetric bandpass, q1.17, center tap last
  localparam logic signed [COEF_W-1:0] COEF_HALF [65] = '{
    -18'sd50, -18'sd92, -18'sd72, 18'sd4, 18'sd62, 18'sd46, -18'sd9, -18'sd9, 18'sd81,
    18'sd181, 18'sd172, 18'sd49, -18'sd52, -18'sd10, 18'sd109, 18'sd104, -18'sd110,
    -18'sd355, -18'sd373, -18'sd152, 18'sd13, -18'sd125, -18'sd415, -18'sd430, 18'sd0,
    18'sd507, 18'sd577, 18'sd205, -18'sd25, 18'sd347, 18'sd1005, 18'sd1132, 18'sd413,
    -18'sd465, -18'sd574, 18'sd64, 18'sd386, -18'sd429, -18'sd1789, -18'sd2227,
    -18'sd1182, 18'sd153, 18'sd171, -18'sd1065, -18'sd1657, -18'sd131, 18'sd2492,
    18'sd3604, 18'sd2142, 18'sd186, 18'sd650, 18'sd3472, 18'sd5083, 18'sd2447,
    -18'sd2785, -18'sd5453, -18'sd2953, 18'sd665, -18'sd1660, -18'sd11358, -18'sd20133,
    -18'sd16460, 18'sd2479, 18'sd25592, 18'sd35979
  };

  function automatic logic signed [COEF_W-1:0] coef_at(input logic [8:0] k);
    logic [8:0] idx;
    idx = (k <= 9'(COEF_MID)) ? k : 9'(COEF_LAST) - k;
    if (k > 9'(COEF_LAST)) return '0;
    return COEF_HALF[idx[6:0]];
  endfunction

  // zero counts as one, large values clip to the limit
  function automatic logic [8:0] eff_count(input logic [8:0] v, input int unsigned limit);
    if (v == 9'd0) return 9'd1;
    if (32'(v) > limit) return 9'(limit);
    return v;
  endfunction

endpackage

### hw/rtl/mfwf_front.sv
// front end: accepts words, tracks step and channel, builds queue entries
module mfwf_front #(
  parameter int MAX_CHANNELS = mfwf_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_WINDOW   = mfwf_pkg::MAX_WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  mfwf_pkg::cfg_t   cfg,
  input  logic             cfg_wr,
  input  logic             in_valid,
  input  logic             in_stall,
  input  mfwf_pkg::in_word_t in_word,
  output logic             push,
  output logic [mfwf_pkg::SAMPLE_W + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)
               + ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1):0] push_data
);
  localparam int T_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [T_W-1:0]  step;
  logic [CH_W-1:0] chan;
  logic [8:0]      nch;
  logic [8:0]      wlen;
  logic            ch_wrap;
  logic            t_wrap;
  logic [mfwf_pkg::SAMPLE_W-1:0] x;

  assign nch     = mfwf_pkg::eff_count({2'b00, cfg.channel_count}, MAX_CHANNELS);
  assign wlen    = mfwf_pkg::eff_count(cfg.win_steps, MAX_WINDOW);
  assign ch_wrap = (32'(chan) + 32'd1) >= 32'(nch);
  assign t_wrap  = (32'(step) + 32'd1) >= 32'(wlen);
  assign push    = in_valid && !in_stall;
  // invalid samples enter the history as zero
  assign x         = in_word.sample_invalid ? '0 : in_word.sample;
  assign push_data = {ch_wrap && t_wrap, chan, step, x};

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      step <= '0;
      chan <= '0;
    end else if (push) begin
      if (ch_wrap) begin
        chan <= '0;
        step <= t_wrap ? '0 : step + 1'b1;
      end else begin
        chan <= chan + 1'b1;
      end
    end
  end
endmodule

### hw/rtl/mfwf_queue.sv
// two-entry queue between front end and filter engine
module mfwf_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic          rvalid,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  assign full   = count == 2'd2;
  assign rvalid = count != 2'd0;
  assign rdata  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

### hw/rtl/mfwf_back.sv
// filter engine: shared mac over the taps, result register, tail rewrite and tail clear
module mfwf_back #(
  parameter int TAP_COUNT    = mfwf_pkg::TAP_COUNT_DEF,
  parameter int MAX_CHANNELS = mfwf_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_WINDOW   = mfwf_pkg::MAX_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mfwf_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  logic [mfwf_pkg::SAMPLE_W + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)
               + ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1):0] q_data,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  output mfwf_pkg::out_word_t out_word,
  input  logic               out_stall
);
  localparam int SW     = mfwf_pkg::SAMPLE_W;
  localparam int ACC_W  = mfwf_pkg::ACC_W;
  localparam int TL     = TAP_COUNT - 1;
  localparam int T_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TDEPTH = TL * MAX_CHANNELS;
  localparam int WDEPTH = MAX_WINDOW * MAX_CHANNELS;
  localparam int TA_W   = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int K_W    = $clog2(TAP_COUNT + 1);
  localparam int LIM_W  = $clog2(TL + 1);
  localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MAC, S_HOLD, S_TUPD} state_t;
  typedef enum logic [1:0] {SRC_WIN, SRC_TAIL, SRC_NONE} src_t;

  state_t state;

  logic [SW-1:0] win_mem  [WDEPTH];
  logic [SW-1:0] tail_mem [TDEPTH];
  logic [SW-1:0] win_q;
  logic [SW-1:0] tail_q;
  logic [WA_W-1:0] win_rd_addr;
  logic [TA_W-1:0] tail_rd_addr;
  logic            win_we;
  logic [WA_W-1:0] win_wa;
  logic            tail_we;
  logic [TA_W-1:0] tail_wa;
  logic [SW-1:0]   tail_wd;

  logic [TA_W-1:0] clr_addr;

  // queue entry fields
  logic [SW-1:0]   q_x;
  logic [T_W-1:0]  q_t;
  logic [CH_W-1:0] q_ch;
  logic            q_last;

  logic [T_W-1:0]  cur_t;
  logic [CH_W-1:0] cur_ch;
  logic            cur_last;
  logic [K_W-1:0]  kcnt;
  logic [WA_W-1:0] win_ra;
  logic [TA_W-1:0] tail_ra;
  logic            p1;
  src_t            p1_sel;
  logic signed [mfwf_pkg::COEF_W-1:0] p1_coef;
  logic            p2;
  logic signed [mfwf_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  src_t            mac_sel;
  logic            mac_issue;
  logic            mac_done;
  logic signed [SW-1:0] tap_val;

  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] qv;
  logic signed [SW-1:0]    sat;
  logic            out_free;

  logic [8:0]       nch;
  logic [8:0]       wlen;
  logic [LIM_W-1:0] lim1;
  logic [LIM_W-1:0] lim2;
  logic [LIM_W-1:0] lim1_next;
  logic [LIM_W-1:0] lim2_next;
  logic [TA_W-1:0]  hoff_next;
  logic [WA_W-1:0]  base_next;
  logic [LIM_W-1:0] tu_i;
  logic [NCH_W-1:0] tu_ch;
  logic [TA_W-1:0]  tsrc;
  logic [TA_W-1:0]  tsrc0;
  logic [WA_W-1:0]  wsrc;
  logic [WA_W-1:0]  wsrc0;
  logic [TA_W-1:0]  dst;
  logic [TA_W-1:0]  dst0;
  logic             tu_issue;
  src_t             tu_kind;
  logic             u_valid;
  src_t             u_kind;
  logic [TA_W-1:0]  u_dst;

  assign q_x    = q_data[SW-1:0];
  assign q_t    = q_data[SW+T_W-1:SW];
  assign q_ch   = q_data[SW+T_W+CH_W-1:SW+T_W];
  assign q_last = q_data[SW+T_W+CH_W];

  assign nch      = mfwf_pkg::eff_count({2'b00, cfg.channel_count}, MAX_CHANNELS);
  assign wlen     = mfwf_pkg::eff_count(cfg.win_steps, MAX_WINDOW);
  assign clearing = state == S_CLEAR;
  assign q_pop    = (state == S_IDLE) && q_valid;

  // history source of tap k: current window, then the stored tail, then nothing
  always_comb begin
    if (32'(kcnt) <= 32'(cur_t)) mac_sel = SRC_WIN;
    else if (32'(kcnt) <= 32'(cur_t) + 32'(TL)) mac_sel = SRC_TAIL;
    else mac_sel = SRC_NONE;
  end
  assign mac_issue = (state == S_MAC) && (32'(kcnt) < 32'(TAP_COUNT));
  assign mac_done  = (state == S_MAC) && !mac_issue && !p1 && !p2;

  always_comb begin
    unique case (p1_sel)
      SRC_WIN:  tap_val = $signed(win_q);
      SRC_TAIL: tap_val = $signed(tail_q);
      default:  tap_val = '0;
    endcase
  end

  // round half up then clip to 24 bits
  assign rnd = acc + ACC_W'(65536);
  assign qv  = rnd >>> mfwf_pkg::ROUND_SHIFT;
  always_comb begin
    if (qv > ACC_W'(8388607)) sat = 24'sh7FFFFF;
    else if (qv < -ACC_W'(8388608)) sat = -24'sh800000;
    else sat = SW'(qv);
  end
  assign out_free = !out_valid || !out_stall;

  // tail rewrite plan: positions below lim1 shift from the tail, below lim2 come from window
  always_comb begin
    int hi;
    int wi;
    int base;
    int l1;
    int l2;
    int ho;
    hi = int'(cfg.hop_length);
    wi = int'(wlen);
    base = 0;
    ho = 0;
    if (hi < TL) begin
      l1 = TL - hi;
      l2 = TL - hi + ((hi < wi) ? hi : wi);
      ho = hi;
    end else if (wi >= TL) begin
      l1 = 0;
      l2 = TL;
      base = (hi < wi) ? hi - TL : wi - TL;
    end else begin
      l1 = 0;
      l2 = wi;
    end
    lim1_next = LIM_W'(l1);
    lim2_next = LIM_W'(l2);
    hoff_next = TA_W'(ho * MAX_CHANNELS);
    base_next = WA_W'(base * MAX_CHANNELS);
  end

  assign tu_issue = (state == S_TUPD) && (32'(tu_ch) < 32'(nch));
  always_comb begin
    if (tu_i < lim1) tu_kind = SRC_TAIL;
    else if (tu_i < lim2) tu_kind = SRC_WIN;
    else tu_kind = SRC_NONE;
  end

  assign win_rd_addr  = (state == S_TUPD) ? wsrc : win_ra;
  assign tail_rd_addr = (state == S_TUPD) ? tsrc : tail_ra;
  assign win_we = q_pop;
  assign win_wa = WA_W'(q_t) * WA_W'(MAX_CHANNELS) + WA_W'(q_ch);

  always_comb begin
    if (state == S_CLEAR) begin
      tail_we = 1'b1;
      tail_wa = clr_addr;
      tail_wd = '0;
    end else begin
      tail_we = u_valid && (u_kind != SRC_NONE);
      tail_wa = u_dst;
      tail_wd = (u_kind == SRC_TAIL) ? tail_q : win_q;
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) win_mem[win_wa] <= q_x;
    win_q <= win_mem[win_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    tail_q <= tail_mem[tail_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      p1        <= 1'b0;
      p2        <= 1'b0;
      u_valid   <= 1'b0;
    end else begin
      // in hold the result register is loaded below instead
      if (out_valid && !out_stall && state != S_HOLD) out_valid <= 1'b0;
      p2 <= p1;
      if (p1) prod <= tap_val * p1_coef;
      if (p2) acc <= acc + ACC_W'(prod);
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == 32'(TDEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur_t    <= q_t;
            cur_ch   <= q_ch;
            cur_last <= q_last;
            kcnt     <= '0;
            acc      <= '0;
            win_ra   <= win_wa;
            tail_ra  <= TA_W'((TL - 1) * MAX_CHANNELS) + TA_W'(q_ch);
            state    <= S_MAC;
          end
        end
        S_MAC: begin
          p1 <= mac_issue;
          if (mac_issue) begin
            p1_sel  <= mac_sel;
            p1_coef <= mfwf_pkg::coef_at(9'(kcnt));
            kcnt    <= kcnt + 1'b1;
            if (mac_sel == SRC_WIN) win_ra <= win_ra - WA_W'(MAX_CHANNELS);
            if (mac_sel == SRC_TAIL) tail_ra <= tail_ra - TA_W'(MAX_CHANNELS);
          end
          if (mac_done) state <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_word.filtered    <= sat;
            out_word.out_channel <= 6'(cur_ch);
            out_word.out_step    <= 8'(cur_t);
            out_word.window_end  <= cur_last;
            if (cur_last) begin
              lim1    <= lim1_next;
              lim2    <= lim2_next;
              tsrc    <= hoff_next;
              tsrc0   <= hoff_next;
              wsrc    <= base_next;
              wsrc0   <= base_next;
              dst     <= '0;
              dst0    <= '0;
              tu_i    <= '0;
              tu_ch   <= '0;
              u_valid <= 1'b0;
              state   <= S_TUPD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_TUPD: begin
          u_valid <= tu_issue;
          if (tu_issue) begin
            u_kind <= tu_kind;
            u_dst  <= dst;
            if (32'(tu_i) == 32'(TL - 1)) begin
              tu_i  <= '0;
              tu_ch <= tu_ch + 1'b1;
              dst   <= dst0 + 1'b1;
              dst0  <= dst0 + 1'b1;
              tsrc  <= tsrc0 + 1'b1;
              tsrc0 <= tsrc0 + 1'b1;
              wsrc  <= wsrc0 + 1'b1;
              wsrc0 <= wsrc0 + 1'b1;
            end else begin
              tu_i <= tu_i + 1'b1;
              dst  <= dst + TA_W'(MAX_CHANNELS);
              tsrc <= tsrc + TA_W'(MAX_CHANNELS);
              if (tu_kind == SRC_WIN) wsrc <= wsrc + WA_W'(MAX_CHANNELS);
            end
          end else if (!u_valid) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hw/rtl/multichannel_fir_window_filter_unit.sv
// top level: multichannel fir window filter with apb configuration
// each accepted word passes the queue, the tap loop of the mac and the result register to its result
// the single shared multiply-accumulate filters one word at a time; the queue holds up to two more
// after the last word of a window the tail rewrite runs before the engine takes the next word
// reset clears the tail memory, with in_stall high until the clear is done
// registers reset to one channel, window 160, hop 80; config writes restart the window
module multichannel_fir_window_filter_unit #(
  parameter int TAP_COUNT    = mfwf_pkg::TAP_COUNT_DEF,
  parameter int MAX_CHANNELS = mfwf_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_WINDOW   = mfwf_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mfwf_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mfwf_pkg::out_word_t              out_word,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mfwf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mfwf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mfwf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  localparam int T_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int QW   = mfwf_pkg::SAMPLE_W + T_W + CH_W + 1;

  mfwf_pkg::cfg_t cfg;
  logic           wr;
  logic           cfg_wr;
  logic [1:0]     reg_idx;
  logic           push;
  logic [QW-1:0]  push_data;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  logic [QW-1:0]  q_data;
  logic           clearing;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite;
  assign cfg_wr  = wr && (reg_idx == mfwf_pkg::REG_CHANNEL_COUNT
                       || reg_idx == mfwf_pkg::REG_WIN_STEPS
                       || reg_idx == mfwf_pkg::REG_HOP_LENGTH);
  assign in_stall = q_full || clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count <= mfwf_pkg::CHANNEL_COUNT_RST;
      cfg.win_steps     <= mfwf_pkg::WIN_STEPS_RST;
      cfg.hop_length    <= mfwf_pkg::HOP_LENGTH_RST;
    end else if (wr) begin
      case (reg_idx)
        mfwf_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[6:0];
        mfwf_pkg::REG_WIN_STEPS:     cfg.win_steps     <= pwdata[8:0];
        mfwf_pkg::REG_HOP_LENGTH:    cfg.hop_length    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mfwf_pkg::REG_CHANNEL_COUNT: prdata = 32'(cfg.channel_count);
      mfwf_pkg::REG_WIN_STEPS:     prdata = 32'(cfg.win_steps);
      mfwf_pkg::REG_HOP_LENGTH:    prdata = 32'(cfg.hop_length);
      default:                     prdata = '0;
    endcase
  end

  mfwf_front #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .push     (push),
    .push_data(push_data)
  );

  mfwf_queue #(
    .DW(QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .full  (q_full),
    .pop   (q_pop),
    .rvalid(q_valid),
    .rdata (q_data)
  );

  mfwf_back #(
    .TAP_COUNT   (TAP_COUNT),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_word (out_word),
    .out_stall(out_stall)
  );
endmodule

### hw/rtl/mfwf_checker.sv
// port-level checks of the fir window filter, bound to the top level
module mfwf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mfwf_pkg::out_word_t out_word
);
  // tail clear keeps the input closed right after reset
  a_stall_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input open right after reset");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result changed");
endmodule

bind multichannel_fir_window_filter_unit mfwf_checker u_mfwf_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);
